### rtl/bzcp_pkg.sv
`default_nettype none

package bzcp_pkg;

  // Coordinates and segment differences.
  localparam int COORD_W    = 32;
  localparam int NUM_COORDS = 8;
  localparam int NUM_LANES  = 4;
  localparam int DIFF_W     = COORD_W + 1;

  // Square roots: length from the squared distance, then the centripetal weight.
  localparam int SQ_IN_W    = 2 * DIFF_W;
  localparam int SQ_OUT_W   = DIFF_W;
  localparam int ROOT_SHIFT = 60 - COORD_W;
  localparam int ROOT_W     = (SQ_OUT_W + ROOT_SHIFT + 1) / 2;
  localparam int WSQ_W      = 2 * ROOT_W;
  localparam int PP_W       = ROOT_W + DIFF_W;

  // Division: the quotient is known to stay below 2^Q_W.
  localparam int DEN_W = 64;
  localparam int NUM_W = 96;
  localparam int Q_W   = 52;
  localparam int SUM_W = Q_W + 2;

  localparam int SKID_DEPTH = 2;
  localparam int SKID_CNT_W = 2;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    coord_t [NUM_LANES-1:0] ctrl;
    logic                   deg_first;
    logic                   deg_second;
    logic                   sat;
  } res_t;

endpackage

`default_nettype wire

### rtl/bzcp_sqrt_pipe.sv
`default_nettype none

// Integer square root, one result bit per register stage.
module bzcp_sqrt_pipe import bzcp_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic [SQ_IN_W-1:0]  rad_i,
  output logic      [SQ_OUT_W-1:0] root_o
);

  logic [SQ_IN_W:0]    rem_q  [SQ_OUT_W];
  logic [SQ_OUT_W-1:0] root_q [SQ_OUT_W];

  for (genvar k = 0; k < SQ_OUT_W; k++) begin : g_st
    localparam int B = SQ_OUT_W - 1 - k;
    logic [SQ_IN_W:0]    rem_in;
    logic [SQ_IN_W:0]    trial;
    logic [SQ_OUT_W-1:0] root_in;

    if (k == 0) begin : g_first
      assign rem_in  = {1'b0, rad_i};
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // (r + 2^B)^2 - r^2, with r holding only bits above B.
    assign trial = ({{(SQ_IN_W+1-SQ_OUT_W){1'b0}}, root_in} << (B + 1))
                 | ((SQ_IN_W+1)'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[k]  <= rem_in - trial;
          root_q[k] <= root_in | (SQ_OUT_W'(1) << B);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[SQ_OUT_W-1];

endmodule

`default_nettype wire

### rtl/bzcp_div_pipe.sv
`default_nettype none

// Restoring division, one quotient bit per register stage. The caller
// guarantees num_i < den_i * 2^Q_W, so only the low Q_W quotient bits exist.
module bzcp_div_pipe import bzcp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  output logic      [Q_W-1:0]    quot_o
);

  logic [DEN_W-1:0] rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   nlo_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_st
    localparam int I = Q_W - 1 - k;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   nlo_in;
    logic [Q_W-1:0]   quo_in;
    logic [DEN_W:0]   shifted;

    if (k == 0) begin : g_first
      assign rem_in = {{(DEN_W-NUM_W+Q_W){1'b0}}, num_i[NUM_W-1:Q_W]};
      assign den_in = den_i;
      assign nlo_in = num_i[Q_W-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign nlo_in = nlo_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign shifted = {rem_in, nlo_in[I]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k] <= den_in;
        nlo_q[k] <= nlo_in;
        if (shifted >= {1'b0, den_in}) begin
          rem_q[k] <= DEN_W'(shifted - {1'b0, den_in});
          quo_q[k] <= {quo_in[Q_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= shifted[DEN_W-1:0];
          quo_q[k] <= {quo_in[Q_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quot_o = quo_q[Q_W-1];

endmodule

`default_nettype wire

### rtl/bzcp_out_skid.sv
`default_nettype none

// Two-entry output buffer. The pipeline moves only while there is room.
module bzcp_out_skid import bzcp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t data_i,
  output logic      room_o,
  output logic      valid_o,
  input  wire logic ready_i,
  output res_t      data_o
);

  res_t                  ent_q [SKID_DEPTH];
  logic [SKID_CNT_W-1:0] cnt_q, cnt_d;
  logic                  wr_q, rd_q;
  logic                  pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q != SKID_CNT_W'(SKID_DEPTH));
  assign data_o  = ent_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + SKID_CNT_W'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - SKID_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SKID_CNT_W'(SKID_DEPTH))
    else $error("skid count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o)
    else $error("item pushed into a full skid buffer");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == SKID_CNT_W'(SKID_DEPTH)) |-> (wr_q == rd_q))
    else $error("skid pointers disagree with count");
`endif

endmodule

`default_nettype wire

### rtl/four_point_bezier_control_points.sv
`default_nettype none

// Centripetal Catmull-Rom to cubic Bezier: takes four points P0..P3 in signed
// Q16.16 and returns the two inner control points of the Bezier segment from
// P1 to P2, each coordinate rounded to nearest and clamped to the 32-bit range
// (saturated_o is then set). The weights are the square roots of the segment
// lengths. When P0 equals P1 the first control point is P1 and
// degenerate_first_o is set; likewise P3 equal to P2 gives P2 and
// degenerate_second_o. The block is a pipeline that takes one item in every
// clock cycle while its output buffer has room. An item passes through
// stages A to C (differences, squares and sums), two 33-stage square roots
// in series (length, then its root), stages D to I (weight and numerator
// arithmetic) and a 52-stage divider, and then sits in a two-entry output
// buffer until taken. The pipeline advances as long as that buffer has room,
// so a stalled result does not hold back input while there is space for it.
module four_point_bezier_control_points import bzcp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire coord_t p0_x_i,
  input  wire coord_t p0_y_i,
  input  wire coord_t p1_x_i,
  input  wire coord_t p1_y_i,
  input  wire coord_t p2_x_i,
  input  wire coord_t p2_y_i,
  input  wire coord_t p3_x_i,
  input  wire coord_t p3_y_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output coord_t      ctrl1_x_o,
  output coord_t      ctrl1_y_o,
  output coord_t      ctrl2_x_o,
  output coord_t      ctrl2_y_o,
  output logic        degenerate_first_o,
  output logic        degenerate_second_o,
  output logic        saturated_o
);

  localparam int SQ_LAT = 2 * SQ_OUT_W;

  typedef coord_t [NUM_COORDS-1:0] pts_t;

  typedef struct packed {
    coord_t [NUM_LANES-1:0] pn;
    logic                   deg1;
    logic                   deg2;
  } side_t;

  typedef struct packed {
    side_t                s;
    logic [NUM_LANES-1:0] neg;
  } dside_t;

  // The whole pipeline moves together while the output buffer has room.
  logic en;
  logic push;
  res_t res;
  res_t out_res;

  assign in_ready_o = en;

  function automatic logic [DIFF_W-1:0] abs_diff(coord_t a, coord_t b);
    logic [DIFF_W-1:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
  endfunction

  // Stage A: absolute coordinate differences of the three segments.
  pts_t              in_pts;
  pts_t              pts_a_q, pts_b_q, pts_c_q;
  logic [DIFF_W-1:0] mag_a_q [6];
  logic [SQ_IN_W-1:0] sq_b_q [6];
  logic [SQ_IN_W-1:0] rad_c_q [3];
  logic              vld_a_q, vld_b_q, vld_c_q;

  assign in_pts = {p3_y_i, p3_x_i, p2_y_i, p2_x_i, p1_y_i, p1_x_i, p0_y_i, p0_x_i};

  always_ff @(posedge clk_i) begin
    if (en) begin
      pts_a_q <= in_pts;
      for (int s = 0; s < 3; s++) begin
        mag_a_q[2*s]   <= abs_diff(in_pts[2*s+2], in_pts[2*s]);
        mag_a_q[2*s+1] <= abs_diff(in_pts[2*s+3], in_pts[2*s+1]);
      end
      // Stage B: squares.
      pts_b_q <= pts_a_q;
      for (int j = 0; j < 6; j++) begin
        sq_b_q[j] <= mag_a_q[j] * mag_a_q[j];
      end
      // Stage C: squared length of each segment.
      pts_c_q <= pts_b_q;
      for (int s = 0; s < 3; s++) begin
        rad_c_q[s] <= sq_b_q[2*s] + sq_b_q[2*s+1];
      end
    end
  end

  // Two square roots in series per segment: the length, then its root.
  logic [SQ_OUT_W-1:0] seg_len  [3];
  logic [SQ_OUT_W-1:0] seg_root [3];

  for (genvar s = 0; s < 3; s++) begin : g_seg
    bzcp_sqrt_pipe u_len (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  (rad_c_q[s]),
      .root_o (seg_len[s])
    );

    bzcp_sqrt_pipe u_root (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  (SQ_IN_W'(seg_len[s]) << ROOT_SHIFT),
      .root_o (seg_root[s])
    );
  end

  pts_t              pts_dl_q [SQ_LAT];
  logic [SQ_LAT-1:0] vld_dl_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pts_dl_q[0] <= pts_c_q;
      for (int k = 1; k < SQ_LAT; k++) begin
        pts_dl_q[k] <= pts_dl_q[k-1];
      end
    end
  end

  // Stage D: weights, sums of roots and the per-lane offsets from the inner point.
  // Lanes: first control point x and y, then second control point x and y.
  pts_t              pts_r;
  logic [ROOT_W-1:0] r1, r2, r3;

  assign pts_r = pts_dl_q[SQ_LAT-1];
  assign r1    = seg_root[0][ROOT_W-1:0];
  assign r2    = seg_root[1][ROOT_W-1:0];
  assign r3    = seg_root[2][ROOT_W-1:0];

  logic [DIFF_W-1:0]    uim_d_q [NUM_LANES];
  logic [DIFF_W-1:0]    uom_d_q [NUM_LANES];
  logic [NUM_LANES-1:0] uin_d_q, uop_d_q;
  logic [ROOT_W-1:0]    r1_d_q, r3_d_q;
  logic [ROOT_W:0]      rs1_d_q, rs2_d_q;
  logic [WSQ_W-1:0]     w1_d_q, w2_d_q, w3_d_q;
  side_t                side_d_q;
  logic                 vld_d_q;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane_d
    localparam int C  = l % 2;
    localparam int PN = (l < 2) ? 2 + C : 4 + C;
    localparam int PI = (l < 2) ? 4 + C : 2 + C;
    localparam int PO = (l < 2) ? C : 6 + C;
    logic [DIFF_W-1:0] ui, uo;

    assign ui = {pts_r[PI][COORD_W-1], pts_r[PI]} - {pts_r[PN][COORD_W-1], pts_r[PN]};
    assign uo = {pts_r[PO][COORD_W-1], pts_r[PO]} - {pts_r[PN][COORD_W-1], pts_r[PN]};

    always_ff @(posedge clk_i) begin
      if (en) begin
        uim_d_q[l]     <= ui[DIFF_W-1] ? (~ui + DIFF_W'(1)) : ui;
        uom_d_q[l]     <= uo[DIFF_W-1] ? (~uo + DIFF_W'(1)) : uo;
        uin_d_q[l]     <= ui[DIFF_W-1];
        uop_d_q[l]     <= !uo[DIFF_W-1];
        side_d_q.pn[l] <= pts_r[PN];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_d_q        <= r1;
      r3_d_q        <= r3;
      rs1_d_q       <= {1'b0, r1} + {1'b0, r2};
      rs2_d_q       <= {1'b0, r3} + {1'b0, r2};
      w1_d_q        <= r1 * r1;
      w2_d_q        <= r2 * r2;
      w3_d_q        <= r3 * r3;
      side_d_q.deg1 <= (r1 == '0);
      side_d_q.deg2 <= (r3 == '0);
    end
  end

  // Stage E: partial products of the numerator terms, and r * (r + r2).
  logic [PP_W-1:0]      t1lo_e_q [NUM_LANES];
  logic [PP_W-1:0]      t1hi_e_q [NUM_LANES];
  logic [PP_W-1:0]      t2lo_e_q [NUM_LANES];
  logic [PP_W-1:0]      t2hi_e_q [NUM_LANES];
  logic [2*ROOT_W:0]    denp_e_q [2];
  logic [NUM_LANES-1:0] uin_e_q, uop_e_q;
  side_t                side_e_q;
  logic                 vld_e_q;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane_e
    logic [WSQ_W-1:0] wa;

    assign wa = (l < 2) ? w1_d_q : w3_d_q;

    always_ff @(posedge clk_i) begin
      if (en) begin
        t1lo_e_q[l] <= wa[ROOT_W-1:0] * uim_d_q[l];
        t1hi_e_q[l] <= wa[WSQ_W-1:ROOT_W] * uim_d_q[l];
        t2lo_e_q[l] <= w2_d_q[ROOT_W-1:0] * uom_d_q[l];
        t2hi_e_q[l] <= w2_d_q[WSQ_W-1:ROOT_W] * uom_d_q[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      denp_e_q[0] <= r1_d_q * rs1_d_q;
      denp_e_q[1] <= r3_d_q * rs2_d_q;
      uin_e_q     <= uin_d_q;
      uop_e_q     <= uop_d_q;
      side_e_q    <= side_d_q;
    end
  end

  // Stage F: full numerator terms and the divisor 3 * r * (r + r2).
  logic [NUM_W-1:0]     t1_f_q [NUM_LANES];
  logic [NUM_W-1:0]     t2_f_q [NUM_LANES];
  logic [DEN_W-1:0]     den_f_q [2];
  logic [NUM_LANES-1:0] uin_f_q, uop_f_q;
  side_t                side_f_q;
  logic                 vld_f_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        t1_f_q[l] <= (NUM_W'(t1hi_e_q[l]) << ROOT_W) + NUM_W'(t1lo_e_q[l]);
        t2_f_q[l] <= (NUM_W'(t2hi_e_q[l]) << ROOT_W) + NUM_W'(t2lo_e_q[l]);
      end
      for (int g = 0; g < 2; g++) begin
        den_f_q[g] <= (DEN_W'(denp_e_q[g]) << 1) + DEN_W'(denp_e_q[g]);
      end
      uin_f_q  <= uin_e_q;
      uop_f_q  <= uop_e_q;
      side_f_q <= side_e_q;
    end
  end

  // Stage G: signed combination. With equal term signs the magnitudes add,
  // otherwise they subtract and the sign comes out of the difference.
  logic [NUM_W-1:0]     s_g_q [NUM_LANES];
  logic [NUM_LANES-1:0] diff_g_q, sa_g_q;
  logic [DEN_W-1:0]     den_g_q [2];
  side_t                side_g_q;
  logic                 vld_g_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        if (uin_f_q[l] == uop_f_q[l]) begin
          s_g_q[l] <= t1_f_q[l] + t2_f_q[l];
        end else if (uin_f_q[l]) begin
          s_g_q[l] <= t2_f_q[l] - t1_f_q[l];
        end else begin
          s_g_q[l] <= t1_f_q[l] - t2_f_q[l];
        end
      end
      diff_g_q <= uin_f_q ^ uop_f_q;
      sa_g_q   <= uin_f_q;
      den_g_q  <= den_f_q;
      side_g_q <= side_f_q;
    end
  end

  // Stage H: magnitude and sign of the numerator.
  logic [NUM_W-1:0]     mag_h_q [NUM_LANES];
  logic [NUM_LANES-1:0] neg_h_q;
  logic [DEN_W-1:0]     den_h_q [2];
  side_t                side_h_q;
  logic                 vld_h_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        if (diff_g_q[l] && s_g_q[l][NUM_W-1]) begin
          mag_h_q[l] <= ~s_g_q[l] + NUM_W'(1);
          neg_h_q[l] <= 1'b1;
        end else begin
          mag_h_q[l] <= s_g_q[l];
          neg_h_q[l] <= diff_g_q[l] ? 1'b0 : sa_g_q[l];
        end
      end
      den_h_q  <= den_g_q;
      side_h_q <= side_g_q;
    end
  end

  // Stage I: add half the divisor so that truncation rounds half away from zero.
  logic [NUM_W-1:0] nr_i_q [NUM_LANES];
  logic [DEN_W-1:0] den_i_q [2];
  dside_t           dside_i_q;
  logic             vld_i_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        nr_i_q[l] <= mag_h_q[l] + NUM_W'(den_h_q[l/2] >> 1);
      end
      den_i_q     <= den_h_q;
      dside_i_q.s <= side_h_q;
      dside_i_q.neg <= neg_h_q;
    end
  end

  logic [Q_W-1:0] quot [NUM_LANES];

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_div
    bzcp_div_pipe u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (nr_i_q[l]),
      .den_i  (den_i_q[l/2]),
      .quot_o (quot[l])
    );
  end

  dside_t         dside_dl_q [Q_W];
  logic [Q_W-1:0] vld_div_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dside_dl_q[0] <= dside_i_q;
      for (int k = 1; k < Q_W; k++) begin
        dside_dl_q[k] <= dside_dl_q[k-1];
      end
    end
  end

  // Valid bits run alongside the data and are the only reset state of the pipe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q   <= 1'b0;
      vld_b_q   <= 1'b0;
      vld_c_q   <= 1'b0;
      vld_dl_q  <= '0;
      vld_d_q   <= 1'b0;
      vld_e_q   <= 1'b0;
      vld_f_q   <= 1'b0;
      vld_g_q   <= 1'b0;
      vld_h_q   <= 1'b0;
      vld_i_q   <= 1'b0;
      vld_div_q <= '0;
    end else if (en) begin
      vld_a_q   <= in_valid_i;
      vld_b_q   <= vld_a_q;
      vld_c_q   <= vld_b_q;
      vld_dl_q  <= {vld_dl_q[SQ_LAT-2:0], vld_c_q};
      vld_d_q   <= vld_dl_q[SQ_LAT-1];
      vld_e_q   <= vld_d_q;
      vld_f_q   <= vld_e_q;
      vld_g_q   <= vld_f_q;
      vld_h_q   <= vld_g_q;
      vld_i_q   <= vld_h_q;
      vld_div_q <= {vld_div_q[Q_W-2:0], vld_i_q};
    end
  end

  // Final step: apply the offset to the inner point, clamp, and pick the
  // inner point itself when the outer segment has zero length.
  dside_t               dside_o;
  logic [NUM_LANES-1:0] lane_sat;

  assign dside_o = dside_dl_q[Q_W-1];

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_out
    logic [SUM_W-1:0]       ext_pn, off, sum;
    logic [SUM_W-COORD_W:0] top_bits;
    logic                   ovf, deg;
    coord_t                 pn, val;

    assign pn       = dside_o.s.pn[l];
    assign ext_pn   = {{(SUM_W-COORD_W){pn[COORD_W-1]}}, pn};
    assign off      = {{(SUM_W-Q_W){1'b0}}, quot[l]};
    assign sum      = dside_o.neg[l] ? (ext_pn - off) : (ext_pn + off);
    assign top_bits = sum[SUM_W-1:COORD_W-1];
    assign ovf      = !((&top_bits) || !(|top_bits));
    assign val      = ovf ? (sum[SUM_W-1] ? COORD_MIN : COORD_MAX) : sum[COORD_W-1:0];
    assign deg      = (l < 2) ? dside_o.s.deg1 : dside_o.s.deg2;

    assign res.ctrl[l] = deg ? pn : val;
    assign lane_sat[l] = !deg && ovf;
  end

  assign res.deg_first  = dside_o.s.deg1;
  assign res.deg_second = dside_o.s.deg2;
  assign res.sat        = |lane_sat;

  assign push = en && vld_div_q[Q_W-1];

  bzcp_out_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .room_o  (en),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_res)
  );

  assign ctrl1_x_o           = out_res.ctrl[0];
  assign ctrl1_y_o           = out_res.ctrl[1];
  assign ctrl2_x_o           = out_res.ctrl[2];
  assign ctrl2_y_o           = out_res.ctrl[3];
  assign degenerate_first_o  = out_res.deg_first;
  assign degenerate_second_o = out_res.deg_second;
  assign saturated_o         = out_res.sat;

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bzcp_pkg::*;

  // Every item produces exactly one result, so the drain allowance and the
  // stall watchdog are both sized well past the pipeline latency.
  localparam int LATENCY     = 127;
  localparam int STALL_LIMIT = 20000;
  localparam int NUM_RANDOM  = 1100;

  typedef struct {
    coord_t c1x, c1y, c2x, c2y;
    logic   deg1, deg2, sat;
  } ctrl_pts_t;

  typedef struct {
    coord_t    p[8];
    logic      known;
    ctrl_pts_t res;
  } quad_row_t;

  logic   clk, rst_n;
  logic   in_valid, in_ready, out_valid, out_ready;
  coord_t pts [8];
  coord_t ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y;
  logic   deg_first, deg_second, sat_flag;

  ctrl_pts_t pending_ctrl[$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  recv_hold = 0;
  bit  stim_done = 0;

  four_point_bezier_control_points dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .p0_x_i(pts[0]), .p0_y_i(pts[1]), .p1_x_i(pts[2]), .p1_y_i(pts[3]),
    .p2_x_i(pts[4]), .p2_y_i(pts[5]), .p3_x_i(pts[6]), .p3_y_i(pts[7]),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .ctrl1_x_o(ctrl1_x), .ctrl1_y_o(ctrl1_y),
    .ctrl2_x_o(ctrl2_x), .ctrl2_y_o(ctrl2_y),
    .degenerate_first_o(deg_first), .degenerate_second_o(deg_second),
    .saturated_o(sat_flag)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor square root of an unsigned value, bit by bit from the top.
  function automatic logic [127:0] isqrt(logic [127:0] v);
    logic [127:0] r, t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Centripetal weight of the segment from a to b.
  function automatic logic [127:0] seg_weight(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    logic signed [127:0] dx, dy;
    logic [127:0] len;
    dx = 128'(signed'(bx)) - 128'(signed'(ax));
    dy = 128'(signed'(by)) - 128'(signed'(ay));
    len = isqrt(dx * dx + dy * dy);
    return isqrt(len << ROOT_SHIFT);
  endfunction

  // One control coordinate: pn plus the weighted offset, rounded half away
  // from zero and clamped to the coordinate range.
  function automatic coord_t ctrl_coord(coord_t pn, coord_t pi, coord_t po,
                                        logic [127:0] wa, logic [127:0] wb,
                                        logic [127:0] den, inout logic sat);
    logic signed [127:0] num, val;
    logic [127:0] mag, q;
    logic neg;
    num = signed'(wa) * (128'(signed'(pi)) - 128'(signed'(pn)))
        - signed'(wb) * (128'(signed'(po)) - 128'(signed'(pn)));
    neg = num < 0;
    mag = neg ? -num : num;
    q = (mag + (den >> 1)) / den;
    if (q > (128'd1 << 62)) q = 128'd1 << 62;
    val = neg ? 128'(signed'(pn)) - signed'(q) : 128'(signed'(pn)) + signed'(q);
    if (val < 128'(signed'(COORD_MIN))) begin
      val = 128'(signed'(COORD_MIN));
      sat = 1'b1;
    end
    if (val > 128'(signed'(COORD_MAX))) begin
      val = 128'(signed'(COORD_MAX));
      sat = 1'b1;
    end
    return coord_t'(val[COORD_W-1:0]);
  endfunction

  function automatic ctrl_pts_t bezier_ctrl(coord_t p[8]);
    ctrl_pts_t r;
    logic [127:0] r1, r2, r3;
    r1 = seg_weight(p[0], p[1], p[2], p[3]);
    r2 = seg_weight(p[2], p[3], p[4], p[5]);
    r3 = seg_weight(p[4], p[5], p[6], p[7]);
    r.sat  = 1'b0;
    r.deg1 = (r1 == 0);
    r.deg2 = (r3 == 0);
    if (r.deg1) begin
      r.c1x = p[2];
      r.c1y = p[3];
    end else begin
      r.c1x = ctrl_coord(p[2], p[4], p[0], r1 * r1, r2 * r2, 3 * r1 * (r1 + r2), r.sat);
      r.c1y = ctrl_coord(p[3], p[5], p[1], r1 * r1, r2 * r2, 3 * r1 * (r1 + r2), r.sat);
    end
    if (r.deg2) begin
      r.c2x = p[4];
      r.c2y = p[5];
    end else begin
      r.c2x = ctrl_coord(p[4], p[2], p[6], r3 * r3, r2 * r2, 3 * r3 * (r3 + r2), r.sat);
      r.c2y = ctrl_coord(p[5], p[3], p[7], r3 * r3, r2 * r2, 3 * r3 * (r3 + r2), r.sat);
    end
    return r;
  endfunction

  // Offers one item, idling first with the current probability, and holds
  // valid and the coordinates steady until the block takes it. Valid is left
  // high afterwards so that the next item can follow in the very next cycle.
  task automatic offer_quad(coord_t p[8], ctrl_pts_t expected);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 8; i++) pts[i] <= p[i];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_ctrl.insert(pending_ctrl.size(), expected);
  endtask

  // Random coordinate: mostly moderate values, sometimes the full range, so
  // that every bit toggles and saturation is provoked now and then.
  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'(signed'($urandom_range(2000000)) - 1000000);
      default: return coord_t'(signed'($urandom_range(1 << 24)) - (1 << 23));
    endcase
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_ctrl.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off that fills the pipeline.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    ctrl_pts_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_ctrl.size() == 0) begin
        $display("%0t: result with nothing expected: %h %h %h %h", $time,
                 ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y);
        errors++;
      end else begin
        e = pending_ctrl.pop_front();
        if (ctrl1_x !== e.c1x || ctrl1_y !== e.c1y || ctrl2_x !== e.c2x ||
            ctrl2_y !== e.c2y || deg_first !== e.deg1 || deg_second !== e.deg2 ||
            sat_flag !== e.sat) begin
          $display("%0t: expected %h %h %h %h d%b%b s%b, got %h %h %h %h d%b%b s%b",
                   $time, e.c1x, e.c1y, e.c2x, e.c2y, e.deg1, e.deg2, e.sat,
                   ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, deg_first, deg_second, sat_flag);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which no item moves on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  quad_row_t dir_rows[$];

  task automatic add_row(coord_t a0, coord_t a1, coord_t a2, coord_t a3,
                         coord_t a4, coord_t a5, coord_t a6, coord_t a7,
                         logic known, ctrl_pts_t res);
    quad_row_t r;
    r.p = '{a0, a1, a2, a3, a4, a5, a6, a7};
    r.known = known;
    r.res = res;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  initial begin
    coord_t    p[8];
    ctrl_pts_t none;
    ctrl_pts_t e;
    int        drain;
    none = '{default: '0};
    rst_n    = 1'b0;
    in_valid = 1'b0;
    for (int i = 0; i < 8; i++) pts[i] = '0;

    // All points equal: both outer segments are zero length, so both inner
    // points pass through and both flags are raised.
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 1, 1, 0});
    add_row(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
            COORD_MAX, COORD_MIN, 1,
            '{COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1, 1, 0});
    // Only one outer segment is degenerate.
    add_row(5, 5, 5, 5, 100, 7, 300, 9, 0, none);
    add_row(-40, 3, 100, 200, 700, -9, 700, -9, 0, none);
    // Zero-length middle segment: both control points are the shared point.
    add_row(0, 0, 65536, 65536, 65536, 65536, 131072, 0, 1,
            '{65536, 65536, 65536, 65536, 0, 0, 0});
    // Collinear evenly spaced points and a plain curve.
    add_row(0, 0, 196608, 0, 393216, 0, 589824, 0, 0, none);
    add_row(0, 0, 65536, 131072, 262144, 131072, 327680, 0, 0, none);
    // Rows of extreme coordinates, some mixed with small values.
    add_row(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
            COORD_MAX, COORD_MAX, 0, none);
    add_row(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
            COORD_MIN, COORD_MIN, 0, none);
    add_row(COORD_MIN, 0, COORD_MAX, 0, COORD_MAX, 1, COORD_MIN, 0, 0, none);
    add_row(0, COORD_MAX, 0, COORD_MIN, 1, COORD_MIN, 1, COORD_MAX, 0, none);
    add_row(-1, -1, 0, 0, 1, 1, 2, 2, 0, none);
    add_row(COORD_MAX, 0, 0, 0, 1, 0, COORD_MIN, 0, 0, none);
    add_row(1, 0, 0, 0, 0, 1, 0, 2, 0, none);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      e = dir_rows[k].known ? dir_rows[k].res : bezier_ctrl(dir_rows[k].p);
      offer_quad(dir_rows[k].p, e);
    end

    // Random items in phases of idling; the sender pauses for a full drain
    // between phases.
    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        3: begin send_idle_pct = 11; recv_stall_pct = 11; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      // Long receiver hold-off, timed in its own process, while the sender
      // keeps offering until the pipeline and its buffer back up.
      if (ph == 4) begin
        recv_hold = 1'b1;
        fork
          begin
            repeat (400) @(posedge clk);
            recv_hold = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < NUM_RANDOM / 5; n++) begin
        if ($urandom_range(9) == 0) begin
          // Repeated points to exercise the degenerate paths at random.
          for (int i = 0; i < 8; i++) p[i] = rand_coord();
          if ($urandom_range(1)) begin p[2] = p[0]; p[3] = p[1]; end
          else begin p[6] = p[4]; p[7] = p[5]; end
        end else begin
          for (int i = 0; i < 8; i++) p[i] = rand_coord();
        end
        offer_quad(p, bezier_ctrl(p));
      end
    end

    in_valid <= 1'b0;
    stim_done = 1'b1;
    drain = 0;
    while (pending_ctrl.size() != 0 && drain < 50 * STALL_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    if (pending_ctrl.size() != 0) begin
      $display("simulation failed");
      $finish;
    end else begin
      repeat (2 * LATENCY) @(posedge clk);
      if (errors == 0)
        $display("simulation ok");
      else
        $display("simulation failed");
      $finish;
    end
  end

endmodule
